[design/bounded_ordered_list_engine_defines.svh]
// Assertion macros shared by the list engine modules.
`ifndef BOUNDED_ORDERED_LIST_ENGINE_DEFINES_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define BOLE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bole assertion failed");

// Next-cycle implication, disabled while reset is high.
`define BOLE_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bole assertion failed");

`endif

[design/bole_pkg.sv]
// Types, codes and constants of the bounded ordered list engine.
package bole_pkg;

   localparam int DEFAULT_CAPACITY = 32;
   localparam int QUEUE_DEPTH      = 2;
   localparam int LEN_W            = 7;
   localparam int OP_W             = 3;

   // commands
   localparam logic [2:0] CMD_INS_FRONT = 3'd0;
   localparam logic [2:0] CMD_INS_REAR  = 3'd1;
   localparam logic [2:0] CMD_DEL_FRONT = 3'd2;
   localparam logic [2:0] CMD_DEL_REAR  = 3'd3;
   localparam logic [2:0] CMD_DISPLAY   = 3'd4;
   localparam logic [2:0] CMD_INS_POS   = 3'd5;
   localparam logic [2:0] CMD_REVERSE   = 3'd6;

   // result status
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_EMPTY  = 2'd1;
   localparam logic [1:0] ST_BADPOS = 2'd2;
   localparam logic [1:0] ST_FULL   = 2'd3;

   // physical operations for the back end
   localparam logic [OP_W-1:0] OP_REPORT   = 3'd0;
   localparam logic [OP_W-1:0] OP_INSERT   = 3'd1;
   localparam logic [OP_W-1:0] OP_DEL_HEAD = 3'd2;
   localparam logic [OP_W-1:0] OP_DEL_TAIL = 3'd3;
   localparam logic [OP_W-1:0] OP_SHOW_FWD = 3'd4;
   localparam logic [OP_W-1:0] OP_SHOW_BWD = 3'd5;

   typedef struct packed {
      logic [2:0]         cmd;
      logic signed [31:0] value;
      logic [5:0]         position;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] element;
      logic [6:0]         element_index;
      logic [6:0]         length;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [1:0]         status;
      logic signed [31:0] value;
      logic [LEN_W-1:0]   slot;
      logic [LEN_W-1:0]   len;
   } op_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_flags_type;

endpackage

[design/bole_front.sv]
// Front end: accepts commands, checks them and turns them into physical list operations.
module bole_front #(
   parameter int CAPACITY = bole_pkg::DEFAULT_CAPACITY
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             q_full,
   input  bole_pkg::req_type req,
   output logic             push,
   output bole_pkg::op_type push_op
);
   import bole_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0] occ_ff, occ_in;
   logic             rev_ff, rev_in;

   logic [LEN_W-1:0] n;
   logic [LEN_W-1:0] pos_ext;
   logic [LEN_W-1:0] lslot;
   logic             is_full;
   op_type           op;

   assign push    = start && !q_full;
   assign push_op = op;

   always_comb begin
      n       = LEN_W'(occ_ff);
      pos_ext = LEN_W'(req.position);
      is_full = (occ_ff == CNT_W'(CAPACITY));
      lslot   = '0;
      op      = '{op: OP_REPORT, status: ST_OK, value: req.value, slot: '0, len: n};
      occ_in  = occ_ff;
      rev_in  = rev_ff;
      unique case (req.cmd) inside
         CMD_INS_FRONT, CMD_INS_REAR, CMD_INS_POS: begin
            if (req.cmd == CMD_INS_REAR) begin
               lslot = n;
            end else if (req.cmd == CMD_INS_POS) begin
               lslot = pos_ext - LEN_W'(1);
            end
            if (is_full) begin
               op.status = ST_FULL;
            end else if (req.cmd == CMD_INS_POS &&
                         (pos_ext == '0 || pos_ext > n + LEN_W'(1))) begin
               op.status = ST_BADPOS;
            end else begin
               op.op   = OP_INSERT;
               // reversed orientation mirrors the slot
               op.slot = rev_ff ? n - lslot : lslot;
               op.len  = n + LEN_W'(1);
               occ_in  = occ_ff + CNT_W'(1);
            end
         end
         CMD_DEL_FRONT, CMD_DEL_REAR: begin
            if (occ_ff == '0) begin
               op.status = ST_EMPTY;
            end else begin
               op.op  = ((req.cmd == CMD_DEL_FRONT) ^ rev_ff) ? OP_DEL_HEAD : OP_DEL_TAIL;
               op.len = n - LEN_W'(1);
               occ_in = occ_ff - CNT_W'(1);
            end
         end
         CMD_DISPLAY: begin
            if (occ_ff == '0) begin
               op.status = ST_EMPTY;
            end else begin
               op.op = rev_ff ? OP_SHOW_BWD : OP_SHOW_FWD;
            end
         end
         CMD_REVERSE: begin
            rev_in = !rev_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
         rev_ff <= 1'b0;
      end else if (push) begin
         occ_ff <= occ_in;
         rev_ff <= rev_in;
      end
   end

endmodule

[design/bole_queue.sv]
// Short operation queue between the front and back ends.
`include "bounded_ordered_list_engine_defines.svh"
module bole_queue #(
   parameter int DEPTH = bole_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  bole_pkg::op_type     push_op,
   input  logic                 pop,
   output bole_pkg::op_type     head,
   output bole_pkg::q_flags_type flags
);
   import bole_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   op_type           slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign head        = slots_ff[rd_ff];
   assign flags.full  = (count_ff == CNT_W'(DEPTH));
   assign flags.empty = (count_ff == '0);

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ff] <= push_op;
      end
   end

   `BOLE_ASSERT_IMP(a_q_no_overflow, clock, reset, push, !flags.full)
   `BOLE_ASSERT_IMP(a_q_no_underflow, clock, reset, pop, !flags.empty)
   `BOLE_ASSERT_NXT(a_q_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + CNT_W'(1))

endmodule

[design/bole_back.sv]
// Back end: shifting register list, display sequencer and result register.
`include "bounded_ordered_list_engine_defines.svh"
module bole_back #(
   parameter int CAPACITY = bole_pkg::DEFAULT_CAPACITY
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bole_pkg::op_type      head,
   input  bole_pkg::q_flags_type flags,
   output logic                  pop,
   output logic                  rsp_valid,
   output bole_pkg::rsp_type     rsp_data
);
   import bole_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);

   logic signed [31:0] entry_ff [CAPACITY];
   logic signed [31:0] entry_in [CAPACITY];

   logic             show_ff, show_in;
   logic             bwd_ff, bwd_in;
   logic [CNT_W-1:0] show_n_ff, show_n_in;
   logic [CNT_W-1:0] show_cnt_ff, show_cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic               ins_go, dhead_go, step_fwd, step_bwd, show_last;
   logic [LEN_W-1:0]   last_pos;
   logic [IDX_W-1:0]   tail_idx;
   logic signed [31:0] tail_val;

   assign pop       = !flags.empty && !show_ff;
   assign ins_go    = pop && head.op == OP_INSERT;
   assign dhead_go  = pop && head.op == OP_DEL_HEAD;
   assign step_fwd  = show_ff && !bwd_ff;
   assign step_bwd  = show_ff && bwd_ff;
   assign last_pos  = LEN_W'(show_n_ff) - LEN_W'(1);
   assign show_last = (show_cnt_ff + CNT_W'(1)) == show_n_ff;
   // tail read: last live element during display, removed tail on rear delete
   assign tail_idx  = show_ff ? IDX_W'(show_n_ff - CNT_W'(1)) : head.len[IDX_W-1:0];
   assign tail_val  = entry_ff[tail_idx];

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      localparam int Lo = (g == 0) ? 0 : g - 1;
      localparam int Hi = (g == CAPACITY - 1) ? g : g + 1;
      localparam logic [LEN_W-1:0] Pos = LEN_W'(g);

      always_comb begin
         entry_in[g] = entry_ff[g];
         if (ins_go) begin
            if (Pos == head.slot) begin
               entry_in[g] = head.value;
            end else if (Pos > head.slot) begin
               entry_in[g] = entry_ff[Lo];
            end
         end else if (dhead_go) begin
            entry_in[g] = entry_ff[Hi];
         end else if (step_fwd) begin
            // rotate toward the head within the live part
            if (Pos == last_pos) begin
               entry_in[g] = entry_ff[0];
            end else if (Pos < last_pos) begin
               entry_in[g] = entry_ff[Hi];
            end
         end else if (step_bwd) begin
            // rotate toward the tail within the live part
            if (Pos == '0) begin
               entry_in[g] = tail_val;
            end else if (Pos <= last_pos) begin
               entry_in[g] = entry_ff[Lo];
            end
         end
      end

      always_ff @(posedge clock) begin
         entry_ff[g] <= entry_in[g];
      end
   end

   always_comb begin
      show_in      = show_ff;
      bwd_in       = bwd_ff;
      show_n_in    = show_n_ff;
      show_cnt_in  = show_cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      if (show_ff) begin
         rsp_valid_in         = 1'b1;
         rsp_in.status        = ST_OK;
         rsp_in.element       = bwd_ff ? tail_val : entry_ff[0];
         rsp_in.element_index = LEN_W'(show_cnt_ff) + LEN_W'(1);
         rsp_in.length        = LEN_W'(show_n_ff);
         rsp_in.last          = show_last;
         show_cnt_in          = show_cnt_ff + CNT_W'(1);
         if (show_last) begin
            show_in = 1'b0;
         end
      end else if (pop) begin
         if (head.op == OP_SHOW_FWD || head.op == OP_SHOW_BWD) begin
            show_in     = 1'b1;
            bwd_in      = (head.op == OP_SHOW_BWD);
            show_n_in   = CNT_W'(head.len);
            show_cnt_in = '0;
         end else begin
            rsp_valid_in         = 1'b1;
            rsp_in.status        = head.status;
            rsp_in.element_index = '0;
            rsp_in.length        = head.len;
            rsp_in.last          = 1'b1;
            if (head.op == OP_DEL_HEAD) begin
               rsp_in.element = entry_ff[0];
            end else if (head.op == OP_DEL_TAIL) begin
               rsp_in.element = tail_val;
            end else begin
               rsp_in.element = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         show_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         show_ff      <= show_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bwd_ff      <= bwd_in;
      show_n_ff   <= show_n_in;
      show_cnt_ff <= show_cnt_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `BOLE_ASSERT_IMP(a_show_nonempty, clock, reset, show_ff, show_n_ff != '0)
   `BOLE_ASSERT_IMP(a_notlast_in_show, clock, reset, rsp_valid_ff && !rsp_ff.last, show_ff)
   `BOLE_ASSERT_NXT(a_show_starts, clock, reset, pop && (head.op == OP_SHOW_FWD || head.op == OP_SHOW_BWD), show_ff)

endmodule

[design/bounded_ordered_list_engine.sv]
// Top level of the bounded ordered list engine.
// Bounded ordered list engine: keeps up to CAPACITY signed 32-bit values in
// order with a count, and runs insert front/rear/at position, delete
// front/rear, display and reverse. A command transfers at a rising edge
// with start high and busy low. Results come out on rsp_data for exactly one
// cycle each, marked by rsp_valid; the receiver cannot stall them, so it
// must take every result as it appears. Every command gives one result,
// except display of a non-empty list, which gives one result per element,
// front first, the final one with last set.
// Rate: the front end takes one command per cycle while the two-entry
// operation queue has room; busy is simply "queue full". The back end takes
// a display as a load of the sequencer, then a step per element, since each
// element is shifted out of the register list in turn; it pops nothing
// meanwhile. So a stream of non-display commands runs at one per cycle, and
// a display holds the back end until its last element is out. A command's
// result passes the queue slot and then the result register before it is on
// the ports; a display puts the sequencer load before its first element.
// Reverse only flips an orientation bit in the front end; the front end
// maps logical positions onto the physical register list, so the list
// itself never moves on a reverse.
module bounded_ordered_list_engine #(
   parameter int CAPACITY = bole_pkg::DEFAULT_CAPACITY
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bole_pkg::req_type req_data,
   output logic              rsp_valid,
   output bole_pkg::rsp_type rsp_data
);
   import bole_pkg::*;

   logic        push;
   logic        pop;
   op_type      push_op;
   op_type      head;
   q_flags_type flags;

   // busy follows the queue fill only
   assign busy = flags.full;

   bole_front #(
      .CAPACITY (CAPACITY)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .q_full  (flags.full),
      .req     (req_data),
      .push    (push),
      .push_op (push_op)
   );

   bole_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .pop     (pop),
      .head    (head),
      .flags   (flags)
   );

   bole_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .flags     (flags),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

[tb/bounded_ordered_list_engine_test.sv]
// Testbench for the bounded ordered list engine: directed and random commands, self-checked.
`timescale 1ns / 100ps

module bounded_ordered_list_engine_test;
   import bole_pkg::*;

   localparam int CAPACITY = DEFAULT_CAPACITY;
   // cmd 7 is not decoded by the block; it must answer with a plain ok
   localparam logic [2:0] CMD_UNUSED = 3'd7;
   // items at the end of the run with no sender gaps
   localparam int QUIET_TAIL = 60;
   localparam int RANDOM_ITEMS = 390;
   // cycles to linger once nothing is outstanding, longer than a full display
   localparam int DRAIN_CYCLES = 80;

   typedef enum {FILL, DRAIN, CHURN} phase_kind;

   // Keeps a software image of the list and the queue of results that the
   // accepted commands must produce, oldest first.
   class list_scoreboard;
      logic signed [31:0] list_image[$];
      rsp_type            due_rsps[$];
      int unsigned        mismatches = 0;

      function int unsigned occupancy();
         return list_image.size();
      endfunction

      function int unsigned pending();
         return due_rsps.size();
      endfunction

      function void push_rsp(logic [1:0] status, logic signed [31:0] element,
                             int unsigned index, bit last);
         rsp_type r;
         r.status        = status;
         r.element       = element;
         r.element_index = index[6:0];
         r.length        = 7'(list_image.size());
         r.last          = last;
         due_rsps.push_back(r);
      endfunction

      // Applies one accepted command to the image and queues its results.
      function void note_command(req_type item);
         logic [1:0]         status;
         logic signed [31:0] removed;
         logic signed [31:0] swap;
         int unsigned        n;
         status  = ST_OK;
         removed = '0;
         n       = list_image.size();
         case (item.cmd) inside
            CMD_INS_FRONT, CMD_INS_REAR, CMD_INS_POS: begin
               if (n >= CAPACITY) begin
                  status = ST_FULL;
               end else if (item.cmd == CMD_INS_FRONT) begin
                  list_image.push_front(item.value);
               end else if (item.cmd == CMD_INS_REAR) begin
                  list_image.push_back(item.value);
               end else if (item.position == 0 || item.position > n + 1) begin
                  status = ST_BADPOS;
               end else begin
                  list_image.insert(item.position - 1, item.value);
               end
            end
            CMD_DEL_FRONT: begin
               if (n == 0) status = ST_EMPTY;
               else removed = list_image.pop_front();
            end
            CMD_DEL_REAR: begin
               if (n == 0) status = ST_EMPTY;
               else removed = list_image.pop_back();
            end
            CMD_DISPLAY: begin
               if (n == 0) begin
                  push_rsp(ST_EMPTY, '0, 0, 1'b1);
               end else begin
                  for (int i = 0; i < n; i++)
                     push_rsp(ST_OK, list_image[i], i + 1, i + 1 == n);
               end
               return;
            end
            CMD_REVERSE: begin
               for (int i = 0; i < n / 2; i++) begin
                  swap                 = list_image[i];
                  list_image[i]         = list_image[n - 1 - i];
                  list_image[n - 1 - i] = swap;
               end
            end
            default: ;
         endcase
         push_rsp(status, removed, 0, 1'b1);
      endfunction

      function void compare_field(string field, logic signed [63:0] want,
                                  logic signed [63:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (due_rsps.size() == 0) begin
            $error("result with nothing outstanding: status %0d element %0d",
                   got.status, got.element);
            mismatches++;
            return;
         end
         want = due_rsps.pop_front();
         compare_field("status", want.status, got.status);
         compare_field("element", want.element, got.element);
         compare_field("element_index", want.element_index, got.element_index);
         compare_field("length", want.length, got.length);
         compare_field("last", want.last, got.last);
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   list_scoreboard sb = new();

   bounded_ordered_list_engine #(
      .CAPACITY(CAPACITY)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop; far beyond the slowest legal run (every item a full
   // display plus the longest sender gap).
   initial begin
      #2_000_000;
      $display("bounded_ordered_list_engine_test NOT OK");
      $finish;
   end

   // Monitor: at each rising edge, a command transfers when start is high and
   // busy low, and a result is on the ports when rsp_valid is high. The
   // command is noted first; its results pass the queue and the result
   // register before they show up, so the ordering here never matters.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) sb.note_command(req_data);
         if (rsp_valid) sb.check_result(rsp_data);
      end
   end

   function automatic logic signed [31:0] pick_value();
      logic signed [31:0] v;
      case ($urandom_range(9, 0))
         0: v = {1'b1, 31'b0};
         1: v = {1'b0, {31{1'b1}}};
         2: v = '0;
         3: v = '1;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   function automatic req_type make_item(logic [2:0] cmd, logic signed [31:0] value,
                                         logic [5:0] position);
      req_type item;
      item.cmd      = cmd;
      item.value    = value;
      item.position = position;
      return item;
   endfunction

   // Random command, weighted by phase: FILL pushes the list to full and
   // keeps inserting into it, DRAIN empties it and keeps deleting, CHURN mixes.
   function automatic req_type pick_command(phase_kind phase, int unsigned occ);
      int unsigned roll;
      logic [5:0]  good_pos;
      logic [5:0]  any_pos;
      logic [2:0]  cmd;
      roll     = $urandom_range(99, 0);
      good_pos = 6'($urandom_range(occ + 1, 1));
      any_pos  = 6'($urandom_range(63, 0));
      case (phase)
         FILL: begin
            if (roll < 30)      cmd = CMD_INS_FRONT;
            else if (roll < 55) cmd = CMD_INS_REAR;
            else if (roll < 90) cmd = CMD_INS_POS;
            else if (roll < 93) cmd = CMD_DISPLAY;
            else if (roll < 96) cmd = CMD_REVERSE;
            else                cmd = roll[0] ? CMD_DEL_FRONT : CMD_DEL_REAR;
            if (roll >= 85 && roll < 90) good_pos = any_pos;
         end
         DRAIN: begin
            if (roll < 35)      cmd = CMD_DEL_FRONT;
            else if (roll < 70) cmd = CMD_DEL_REAR;
            else if (roll < 78) cmd = CMD_DISPLAY;
            else if (roll < 84) cmd = CMD_REVERSE;
            else if (roll < 88) cmd = CMD_INS_FRONT;
            else if (roll < 92) cmd = CMD_INS_REAR;
            else if (roll < 97) cmd = CMD_INS_POS;
            else                cmd = CMD_UNUSED;
            if (roll >= 92 && roll < 95) good_pos = any_pos;
         end
         default: begin
            if (roll < 12)      cmd = CMD_INS_FRONT;
            else if (roll < 24) cmd = CMD_INS_REAR;
            else if (roll < 36) cmd = CMD_DEL_FRONT;
            else if (roll < 48) cmd = CMD_DEL_REAR;
            else if (roll < 58) cmd = CMD_DISPLAY;
            else if (roll < 68) cmd = CMD_REVERSE;
            else if (roll < 72) cmd = CMD_UNUSED;
            else                cmd = CMD_INS_POS;
            if (roll >= 72 && roll < 80) good_pos = any_pos;
         end
      endcase
      // payload bits are randomized even where the command ignores them
      if (cmd != CMD_INS_POS) good_pos = any_pos;
      return make_item(cmd, pick_value(), good_pos);
   endfunction

   // Called at a falling edge; start drops for the whole gap,
   // with junk on the payload to show it is ignored.
   task automatic hold_off(input int unsigned cycles);
      start    <= 1'b0;
      req_data <= make_item(3'($urandom_range(7, 0)), $urandom,
                            6'($urandom_range(63, 0)));
      repeat (cycles) @(negedge clock);
   endtask

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_command(input req_type item, input bit quiet);
      if (!quiet && $urandom_range(3, 0) == 0) hold_off($urandom_range(9, 1));
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   initial begin
      phase_kind   phase;
      int unsigned phase_items;
      int unsigned edge_items;
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: everything on an empty list first, then the position rules
      // and value extremes on a short list.
      send_command(make_item(CMD_DISPLAY,   '0, 6'd0), 1'b0);
      send_command(make_item(CMD_DEL_FRONT, '0, 6'd0), 1'b0);
      send_command(make_item(CMD_DEL_REAR,  '0, 6'd0), 1'b0);
      send_command(make_item(CMD_REVERSE,   '0, 6'd0), 1'b0);
      send_command(make_item(CMD_UNUSED,    '1, 6'd63), 1'b0);
      send_command(make_item(CMD_INS_POS,   32'sd5, 6'd0), 1'b0);
      send_command(make_item(CMD_INS_POS,   32'sd6, 6'd2), 1'b0);
      send_command(make_item(CMD_INS_POS,   32'sd7, 6'd63), 1'b0);
      send_command(make_item(CMD_INS_POS,   {1'b0, {31{1'b1}}}, 6'd1), 1'b0);
      send_command(make_item(CMD_INS_FRONT, {1'b1, 31'b0}, 6'd0), 1'b0);
      send_command(make_item(CMD_INS_REAR,  '1, 6'd0), 1'b0);
      send_command(make_item(CMD_INS_REAR,  '0, 6'd0), 1'b0);
      send_command(make_item(CMD_INS_POS,   32'sd100, 6'd5), 1'b0);
      send_command(make_item(CMD_INS_POS,   32'sd200, 6'd3), 1'b0);
      send_command(make_item(CMD_DISPLAY,   '0, 6'd0), 1'b0);
      send_command(make_item(CMD_REVERSE,   '0, 6'd0), 1'b0);
      send_command(make_item(CMD_DISPLAY,   '0, 6'd0), 1'b0);
      send_command(make_item(CMD_UNUSED,    '0, 6'd0), 1'b0);
      send_command(make_item(CMD_DEL_FRONT, '0, 6'd0), 1'b0);
      send_command(make_item(CMD_DEL_REAR,  '0, 6'd0), 1'b0);
      send_command(make_item(CMD_INS_POS,   32'sd9, 6'd63), 1'b0);
      send_command(make_item(CMD_DISPLAY,   '0, 6'd0), 1'b0);

      // Random: start by filling up so the full-list answer is reached early.
      // FILL ends a few items after the list is full, DRAIN a few after it
      // is empty, CHURN after a fixed stretch; any phase gives up after 60.
      phase       = FILL;
      phase_items = 0;
      edge_items  = 0;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         send_command(pick_command(phase, sb.occupancy()),
                      i >= RANDOM_ITEMS - QUIET_TAIL);
         phase_items++;
         if ((phase == FILL && sb.occupancy() == CAPACITY) ||
             (phase == DRAIN && sb.occupancy() == 0))
            edge_items++;
         if (edge_items >= 4 || phase_items >= 60 ||
             (phase == CHURN && phase_items >= 30)) begin
            case ($urandom_range(2, 0))
               0: phase = FILL;
               1: phase = DRAIN;
               default: phase = CHURN;
            endcase
            phase_items = 0;
            edge_items  = 0;
         end
      end
      start <= 1'b0;

      // Drain: every outstanding result, then a margin for anything extra.
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("bounded_ordered_list_engine_test OK");
      end else begin
         $display("bounded_ordered_list_engine_test NOT OK");
      end
      $finish;
   end

endmodule

[bounded_ordered_list_engine.f]
+incdir+design
design/bole_pkg.sv
design/bole_front.sv
design/bole_queue.sv
design/bole_back.sv
design/bounded_ordered_list_engine.sv
tb/bounded_ordered_list_engine_test.sv
